[rtl/core/mstd_pkg.sv]
// ----------------------------------------------------------------------------
// mstd_pkg: shared definitions of the seven-tap decimator
// Types and codes used by more than one module of the seven-tap 2:1
// decimating line filter, and the arithmetic helpers of its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mstd_pkg;

   localparam int PAIR_W            = 11;
   localparam int SAMPLE_W          = 8;
   localparam int MAX_PAIRS_DEFAULT = 1024;
   localparam int MIN_PAIRS         = 4;
   localparam int PAIR_RESET        = 320;
   localparam int TAP_COUNT         = 7;
   localparam int SUM_W             = 19;
   localparam int FIFO_DEPTH        = 8;

   // What a sample at a given line position produces.
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SECOND = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MID    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic valid;
      logic pair;
   } push_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] filtered;
      logic                line_end;
   } result_type;

   // Rounding, clamping and scaling of one filter sum to an 8-bit result.
   function automatic logic [SAMPLE_W-1:0] squash(input sum_type sum);
      sum_type t;
      t = sum + SUM_W'(127);
      if (t < 0) begin
         squash = '0;
      end else if (t > SUM_W'(32'hFFFF)) begin
         squash = 8'hFF;
      end else begin
         squash = t[15:8];
      end
   endfunction

   // Constant-coefficient product of one unsigned sample.
   function automatic sum_type tap(input sample_type s, input int coef);
      sum_type ext;
      ext = $signed({{(SUM_W-SAMPLE_W){1'b0}}, s});
      tap = ext * SUM_W'(coef);
   endfunction

endpackage

`default_nettype wire

[rtl/core/mpeg_seven_tap_decimator.sv]
// ----------------------------------------------------------------------------
// mpeg_seven_tap_decimator: seven-tap 2:1 decimating line filter
// Filters a line of 8-bit samples with the taps -29,0,88,138,88,0,-29 and
// keeps every second centre, with the line edges folded.
// ----------------------------------------------------------------------------
// The block takes one sample per clock and produces one filtered output for
// every second input sample. A line holds 2*pair_count samples, where
// pair_count is clamped to the range 4 to MAX_PAIRS. The output for centre
// i-3 leaves after the sample at each odd index i from 3 up; the last sample
// of a line yields two outputs, and the second of them carries line_end.
// A result passes through the work register, the sum registers and the
// result queue before it raises rsp_valid.
// Sustained rate is one input transaction per cycle: results wait in an
// eight-entry queue, and the input is stalled only while that queue, counting
// results still in the pipeline, has fewer than two free places.
// Writing pair_count through the csr_ port restarts the line, so the next
// sample is index 0 of a new line; the port is always ready, and a write is
// meant to happen only while no results are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_seven_tap_decimator
   import mstd_pkg::*;
#(
   parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_filtered,
   output logic                     rsp_line_end,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [PAIR_W-1:0]   csr_pair_count
);

   // Width of a clamped pair count, of a line position and of the compare.
   localparam int EW    = $clog2(MAX_PAIRS + 1);
   localparam int PW    = EW + 1;
   localparam int CW    = (EW > PAIR_W) ? EW : PAIR_W;
   localparam int RES_W = $clog2(FIFO_DEPTH) + 1;

   logic [PAIR_W-1:0] pair_count_ff;
   logic [PAIR_W-1:0] pair_count_in;
   logic [PW-1:0]     position_ff;
   logic [PW-1:0]     position_in;
   logic [RES_W-1:0]  reserved_ff;
   logic [RES_W-1:0]  reserved_in;
   logic              work_valid_ff;
   logic [KIND_W-1:0] work_kind_ff;

   logic [CW-1:0]     pc_ext;
   logic [EW-1:0]     eff_pairs;
   logic [PW-1:0]     last_idx;
   logic [KIND_W-1:0] kind;
   logic [RES_W-1:0]  n_results;
   logic              req_accept;
   logic              rsp_accept;
   logic              csr_accept;

   sample_type        taps [TAP_COUNT];
   push_type          push;
   sum_type           sum_a;
   sum_type           sum_b;
   result_type        entry_a;
   result_type        entry_b;
   result_type        head;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // The queue must have room for the two results of a line end in the
   // worst case, counting everything still on its way through the pipeline.
   assign req_stall = (reserved_ff > RES_W'(FIFO_DEPTH - 2));

   // Clamp the line length and find where in the line this sample sits.
   always_comb begin
      pc_ext = CW'(pair_count_ff);
      if (pc_ext < CW'(MIN_PAIRS)) begin
         eff_pairs = EW'(MIN_PAIRS);
      end else if (pc_ext > CW'(MAX_PAIRS)) begin
         eff_pairs = EW'(MAX_PAIRS);
      end else begin
         eff_pairs = EW'(pc_ext);
      end
      last_idx = {eff_pairs, 1'b0} - PW'(1);

      if (position_ff == last_idx) begin
         kind = KIND_END;
      end else if (position_ff[0] && position_ff >= PW'(3)) begin
         // Any odd index from 3 up that is below the last one yields a single result.
         if (position_ff == PW'(3)) begin
            kind = KIND_FIRST;
         end else if (position_ff == PW'(5)) begin
            kind = KIND_SECOND;
         end else begin
            kind = KIND_MID;
         end
      end else begin
         kind = KIND_NONE;
      end

      case (kind)
         KIND_NONE: n_results = RES_W'(0);
         KIND_END:  n_results = RES_W'(2);
         default:   n_results = RES_W'(1);
      endcase

      pair_count_in = pair_count_ff;
      position_in   = position_ff;
      if (csr_accept) begin
         pair_count_in = csr_pair_count;
         position_in   = '0;
      end else if (req_accept) begin
         position_in = (position_ff >= last_idx) ? '0 : position_ff + PW'(1);
      end

      reserved_in = reserved_ff + (req_accept ? n_results : RES_W'(0))
                  - RES_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= PAIR_W'(PAIR_RESET);
         position_ff   <= '0;
         reserved_ff   <= '0;
         work_valid_ff <= 1'b0;
         work_kind_ff  <= KIND_NONE;
      end else begin
         pair_count_ff <= pair_count_in;
         position_ff   <= position_in;
         reserved_ff   <= reserved_in;
         work_valid_ff <= req_accept && (kind != KIND_NONE);
         if (req_accept) begin
            work_kind_ff <= kind;
         end
      end
   end

   // The tap chain: cell 0 takes the incoming sample, every other cell takes
   // its neighbor's sample, so cell k holds the sample k steps back.
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      if (k == 0) begin : g_head
         mstd_tap_cell u_cell (
            .clock      (clock),
            .shift      (req_accept),
            .sample_in  (req_sample),
            .sample_out (taps[k])
         );
      end else begin : g_body
         mstd_tap_cell u_cell (
            .clock      (clock),
            .shift      (req_accept),
            .sample_in  (taps[k-1]),
            .sample_out (taps[k])
         );
      end
   end

   // The chain holds still for the cycle after an accept unless another
   // sample arrives, and the sums are taken in exactly that cycle.
   mstd_sum_unit u_sum (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid_ff),
      .work_kind  (work_kind_ff),
      .taps       (taps),
      .push       (push),
      .sum_a      (sum_a),
      .sum_b      (sum_b)
   );

   always_comb begin
      entry_a.filtered = squash(sum_a);
      entry_a.line_end = 1'b0;
      entry_b.filtered = squash(sum_b);
      entry_b.line_end = 1'b1;
   end

   mstd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_a   (entry_a),
      .entry_b   (entry_b),
      .pop       (rsp_accept),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_filtered = head.filtered;
   assign rsp_line_end = head.line_end;

endmodule

`default_nettype wire

[rtl/core/mstd_tap_cell.sv]
// ----------------------------------------------------------------------------
// mstd_tap_cell: one storage cell of the tap chain
// Holds one sample and hands it to the next cell each time the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module mstd_tap_cell
   import mstd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire sample_type sample_in,
   output sample_type      sample_out
);

   sample_type sample_ff;
   sample_type sample_in_w;

   always_comb begin
      sample_in_w = shift ? sample_in : sample_ff;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_w;
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

[rtl/core/mstd_sum_unit.sv]
// ----------------------------------------------------------------------------
// mstd_sum_unit: filter sum stage
// Forms the one or two tap sums that a sample position calls for, with the
// edge folding applied, and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module mstd_sum_unit
   import mstd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              work_valid,
   input  wire logic [KIND_W-1:0] work_kind,
   input  wire sample_type        taps [TAP_COUNT],
   output push_type               push,
   output sum_type                sum_a,
   output sum_type                sum_b
);

   push_type push_ff;
   push_type push_in;
   sum_type  sum_a_ff;
   sum_type  sum_a_in;
   sum_type  sum_b_ff;

   // taps[k] is the sample k steps back from the one that triggered the work.
   always_comb begin
      push_in.valid = work_valid;
      push_in.pair  = (work_kind == KIND_END);
      case (work_kind)
         KIND_FIRST: begin
            sum_a_in = tap(taps[3], 197) + tap(taps[2], 88) - tap(taps[0], 29);
         end
         KIND_SECOND: begin
            sum_a_in = tap(taps[4], 59) + tap(taps[3], 138) + tap(taps[2], 88)
                     - tap(taps[0], 29);
         end
         KIND_END: begin
            sum_a_in = tap(taps[4], 88) + tap(taps[3], 138) + tap(taps[2], 59)
                     - tap(taps[6], 29);
         end
         default: begin
            sum_a_in = tap(taps[4], 88) + tap(taps[3], 138) + tap(taps[2], 88)
                     - tap(taps[6], 29) - tap(taps[0], 29);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= '0;
      end else begin
         push_ff <= push_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_a_ff <= sum_a_in;
      sum_b_ff <= tap(taps[2], 88) + tap(taps[1], 197) - tap(taps[4], 29);
   end

   assign push  = push_ff;
   assign sum_a = sum_a_ff;
   assign sum_b = sum_b_ff;

endmodule

`default_nettype wire

[rtl/core/mstd_result_fifo.sv]
// ----------------------------------------------------------------------------
// mstd_result_fifo: result queue
// Takes one or two results per cycle and delivers them one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mstd_result_fifo
   import mstd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   input  wire result_type entry_a,
   input  wire result_type entry_b,
   input  wire logic       pop,
   output logic            not_empty,
   output result_type      head
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   result_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] n_push;

   always_comb begin
      n_push = !push.valid ? CNT_W'(0) : (push.pair ? CNT_W'(2) : CNT_W'(1));
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= entry_a;
         if (push.pair) begin
            mem_ff[wr_ptr_ff + PTR_W'(1)] <= entry_b;
         end
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire
